// ===== sv/hsv_to_rgb_converter_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the HSV to RGB converter
// Shared helpers so that every module asserts with the same clock and reset.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_TOP_ASSERT_SVH

// Property that must hold in the same cycle as its antecedent.
`define HSV2RGB_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv2rgb: same-cycle check failed");

// Property that must hold in the cycle after its antecedent.
`define HSV2RGB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsv2rgb: next-cycle check failed");

`endif

// ===== sv/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, fixed-point constants, sector codes and the stage payload type.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int SECTOR_FRAC_BITS = 12;
  localparam int LEVEL_FRAC_BITS  = 16;

  localparam int HUE_W    = 15;
  localparam int LEVEL_W  = LEVEL_FRAC_BITS + 1;
  localparam int WEIGHT_W = SECTOR_FRAC_BITS + 1;
  localparam int SECTOR_W = 3;
  localparam int BYTE_W   = 8;

  typedef logic [HUE_W-1:0]    hue_t;
  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [BYTE_W-1:0]   byte_t;

  localparam level_t  LEVEL_ONE  = level_t'(1) << LEVEL_FRAC_BITS;
  localparam weight_t SECTOR_ONE = weight_t'(1) << SECTOR_FRAC_BITS;
  localparam hue_t    FULL_TURN  = hue_t'(6) << SECTOR_FRAC_BITS;

  // One 60-degree sector of the hue circle.
  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

  // Levels handed from the arithmetic front end to the routing back end.
  typedef struct packed {
    level_t  x;
    level_t  m;
    level_t  v;
    sector_t sector;
  } mid_t;

endpackage

// ===== sv/hsv2rgb_if.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB channel interfaces
// Valid/ready channels for the HSV input colour and the RGB output colour.
// ----------------------------------------------------------------------------
interface hsv2rgb_hsv_if;
  logic                valid;
  logic                ready;
  hsv2rgb_pkg::hue_t   hue_in;
  hsv2rgb_pkg::level_t sat_in;
  hsv2rgb_pkg::level_t val_in;

  modport source (output valid, output hue_in, output sat_in, output val_in, input ready);
  modport sink   (input valid, input hue_in, input sat_in, input val_in, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic               valid;
  logic               ready;
  hsv2rgb_pkg::byte_t red_out;
  hsv2rgb_pkg::byte_t green_out;
  hsv2rgb_pkg::byte_t blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== sv/hsv_to_rgb_converter_top.sv =====
// Each accepted HSV transaction passes every stage register in order to its RGB result.
// One colour per cycle while the output is not stalled; the five stages advance together.
// The multiply stages (saturation times value, then chroma times weight) set the depth.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (rst, synchronous, active high) empties every stage; data is not cleared.
// ----------------------------------------------------------------------------
// HSV to RGB converter top level
// Five-stage pipeline turning hue/saturation/value into 8-bit red/green/blue.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top (
  input  logic          clk,
  input  logic          rst,
  hsv2rgb_hsv_if.sink   hsv,
  hsv2rgb_rgb_if.source rgb
);
  import hsv2rgb_pkg::*;

  logic  en;
  logic  mid_valid;
  mid_t  mid;
  logic  out_valid;
  byte_t red;
  byte_t green;
  byte_t blue;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en        = !out_valid || rgb.ready;
  assign hsv.ready = en;

  hsv2rgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (hsv.valid),
    .hue       (hsv.hue_in),
    .sat       (hsv.sat_in),
    .val       (hsv.val_in),
    .mid_valid (mid_valid),
    .mid       (mid)
  );

  hsv2rgb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .mid_valid (mid_valid),
    .mid       (mid),
    .out_valid (out_valid),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign rgb.valid     = out_valid;
  assign rgb.red_out   = red;
  assign rgb.green_out = green;
  assign rgb.blue_out  = blue;

endmodule

// ===== sv/hsv2rgb_front.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Three stages: input decode, chroma multiply, then sector weighting.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_top_assert.svh"

module hsv2rgb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  hsv2rgb_pkg::hue_t   hue,
  input  hsv2rgb_pkg::level_t sat,
  input  hsv2rgb_pkg::level_t val,
  output logic                mid_valid,
  output hsv2rgb_pkg::mid_t   mid
);
  import hsv2rgb_pkg::*;

  // Stage 1 registers.
  logic    valid1;
  level_t  s1;
  level_t  v1;
  sector_t sector1;
  weight_t weight1;

  // Stage 2 registers.
  logic    valid2;
  level_t  c2;
  level_t  v2;
  sector_t sector2;
  weight_t weight2;

  // Stage 3 registers.
  logic    valid3;
  mid_t    mid3;

  level_t  s_clamp;
  level_t  v_clamp;
  sector_t sector_dec;
  weight_t weight_dec;
  logic [2*LEVEL_W-1:0]        sv_prod;
  logic [LEVEL_W+WEIGHT_W-1:0] cw_prod;

  // A hue of a full turn or more sits at the end of the last sector, where
  // the falling weight is zero and the colour matches hue zero.
  always_comb begin
    s_clamp = (sat > LEVEL_ONE) ? LEVEL_ONE : sat;
    v_clamp = (val > LEVEL_ONE) ? LEVEL_ONE : val;
    if (hue >= FULL_TURN) begin
      sector_dec = SEC_MAGENTA_RED;
      weight_dec = '0;
    end else begin
      sector_dec = sector_t'(hue[HUE_W-1 -: SECTOR_W]);
      if (hue[SECTOR_FRAC_BITS]) begin
        weight_dec = SECTOR_ONE - weight_t'(hue[SECTOR_FRAC_BITS-1:0]);
      end else begin
        weight_dec = weight_t'(hue[SECTOR_FRAC_BITS-1:0]);
      end
    end
  end

  assign sv_prod = s1 * v1;
  assign cw_prod = c2 * weight2;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
    end else if (en) begin
      valid1 <= in_valid;
      valid2 <= valid1;
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1          <= s_clamp;
      v1          <= v_clamp;
      sector1     <= sector_dec;
      weight1     <= weight_dec;
      c2          <= sv_prod[LEVEL_FRAC_BITS +: LEVEL_W];
      v2          <= v1;
      sector2     <= sector1;
      weight2     <= weight1;
      mid3.x      <= cw_prod[SECTOR_FRAC_BITS +: LEVEL_W];
      mid3.m      <= v2 - c2;
      mid3.v      <= v2;
      mid3.sector <= sector2;
    end
  end

  assign mid_valid = valid3;
  assign mid       = mid3;

  `HSV2RGB_ASSERT_SAME(a_weight_range, valid1, weight1 <= SECTOR_ONE)
  `HSV2RGB_ASSERT_SAME(a_chroma_below_value, valid2, c2 <= v2)
  `HSV2RGB_ASSERT_NEXT(a_zero_sat_no_chroma, valid1 && en && (s1 == '0), c2 == '0)

endmodule

// ===== sv/hsv2rgb_back.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Two stages: route levels to channels by sector, then scale to bytes.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_top_assert.svh"

module hsv2rgb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               mid_valid,
  input  hsv2rgb_pkg::mid_t  mid,
  output logic               out_valid,
  output hsv2rgb_pkg::byte_t red,
  output hsv2rgb_pkg::byte_t green,
  output hsv2rgb_pkg::byte_t blue
);
  import hsv2rgb_pkg::*;

  logic   valid4;
  level_t r4;
  level_t g4;
  level_t b4;

  logic   valid5;
  byte_t  r5;
  byte_t  g5;
  byte_t  b5;

  level_t rise;
  level_t r_sel;
  level_t g_sel;
  level_t b_sel;

  // level * 255 as a shift and subtract, keeping the integer part.
  function automatic byte_t scale_byte(input level_t lvl);
    logic [LEVEL_W+BYTE_W-1:0] wide;
    wide = ({{BYTE_W{1'b0}}, lvl} << BYTE_W) - {{BYTE_W{1'b0}}, lvl};
    return wide[LEVEL_FRAC_BITS +: BYTE_W];
  endfunction

  assign rise = mid.x + mid.m;

  always_comb begin
    case (mid.sector)
      SEC_RED_YELLOW: begin
        r_sel = mid.v; g_sel = rise;  b_sel = mid.m;
      end
      SEC_YELLOW_GREEN: begin
        r_sel = rise;  g_sel = mid.v; b_sel = mid.m;
      end
      SEC_GREEN_CYAN: begin
        r_sel = mid.m; g_sel = mid.v; b_sel = rise;
      end
      SEC_CYAN_BLUE: begin
        r_sel = mid.m; g_sel = rise;  b_sel = mid.v;
      end
      SEC_BLUE_MAGENTA: begin
        r_sel = rise;  g_sel = mid.m; b_sel = mid.v;
      end
      default: begin
        r_sel = mid.v; g_sel = mid.m; b_sel = rise;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      valid5 <= 1'b0;
    end else if (en) begin
      valid4 <= mid_valid;
      valid5 <= valid4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r4 <= r_sel;
      g4 <= g_sel;
      b4 <= b_sel;
      r5 <= scale_byte(r4);
      g5 <= scale_byte(g4);
      b5 <= scale_byte(b4);
    end
  end

  assign out_valid = valid5;
  assign red       = r5;
  assign green     = g5;
  assign blue      = b5;

  `HSV2RGB_ASSERT_SAME(a_rise_below_value, mid_valid, rise <= mid.v)
  `HSV2RGB_ASSERT_SAME(a_value_routed, valid4, (r4 >= g4 && r4 >= b4) ||
                       (g4 >= r4 && g4 >= b4) || (b4 >= r4 && b4 >= g4))
  `HSV2RGB_ASSERT_NEXT(a_grey_stays_grey, valid4 && en && (r4 == g4) && (g4 == b4),
                       (r5 == g5) && (g5 == b5))

endmodule

// ===== tb/sv/hsv_to_rgb_converter_checker.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter result checker
// Watches both channels, works out the RGB colour of every accepted HSV
// transaction and compares each RGB transaction with the oldest one waiting.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker (
  input  logic        clk,
  input  logic        rst,
  hsv2rgb_hsv_if      hsv,
  hsv2rgb_rgb_if      rgb,
  output int unsigned errors,
  output int unsigned outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsv2rgb_pkg::*;

  localparam logic [63:0] BYTE_SCALE = 64'd255;

  typedef struct packed {
    hue_t   hue;
    level_t sat;
    level_t val;
    byte_t  red;
    byte_t  green;
    byte_t  blue;
  } color_entry_t;

  color_entry_t expected_colors[$];

  function automatic byte_t level_to_byte(logic [63:0] level);
    logic [63:0] scaled;
    scaled = (level * BYTE_SCALE) >> LEVEL_FRAC_BITS;
    return byte_t'(scaled);
  endfunction

  function automatic color_entry_t convert_color(hue_t hue, level_t sat, level_t val);
    logic [63:0]  h;
    logic [63:0]  s;
    logic [63:0]  v;
    logic [63:0]  frac;
    logic [63:0]  weight;
    logic [63:0]  chroma;
    logic [63:0]  floor_lvl;
    logic [63:0]  rise;
    logic [63:0]  lr;
    logic [63:0]  lg;
    logic [63:0]  lb;
    sector_t      sector;
    color_entry_t entry;
    h = (hue > FULL_TURN) ? 64'(FULL_TURN) : 64'(hue);
    s = (sat > LEVEL_ONE) ? 64'(LEVEL_ONE) : 64'(sat);
    v = (val > LEVEL_ONE) ? 64'(LEVEL_ONE) : 64'(val);
    // A full turn sits at the far end of the last sector, not in a seventh one.
    if (h == 64'(FULL_TURN)) begin
      sector = SEC_MAGENTA_RED;
      frac   = 64'(SECTOR_ONE);
    end else begin
      sector = sector_t'(h[SECTOR_FRAC_BITS +: SECTOR_W]);
      frac   = h & (64'(SECTOR_ONE) - 64'd1);
    end
    chroma    = (s * v) >> LEVEL_FRAC_BITS;
    floor_lvl = v - chroma;
    if (sector == SEC_YELLOW_GREEN || sector == SEC_CYAN_BLUE || sector == SEC_MAGENTA_RED) begin
      weight = 64'(SECTOR_ONE) - frac;
    end else begin
      weight = frac;
    end
    rise = ((chroma * weight) >> SECTOR_FRAC_BITS) + floor_lvl;
    case (sector)
      SEC_RED_YELLOW: begin
        lr = v;         lg = rise;      lb = floor_lvl;
      end
      SEC_YELLOW_GREEN: begin
        lr = rise;      lg = v;         lb = floor_lvl;
      end
      SEC_GREEN_CYAN: begin
        lr = floor_lvl; lg = v;         lb = rise;
      end
      SEC_CYAN_BLUE: begin
        lr = floor_lvl; lg = rise;      lb = v;
      end
      SEC_BLUE_MAGENTA: begin
        lr = rise;      lg = floor_lvl; lb = v;
      end
      default: begin
        lr = v;         lg = floor_lvl; lb = rise;
      end
    endcase
    entry.hue   = hue;
    entry.sat   = sat;
    entry.val   = val;
    entry.red   = level_to_byte(lr);
    entry.green = level_to_byte(lg);
    entry.blue  = level_to_byte(lb);
    return entry;
  endfunction

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin : watch_channels
    color_entry_t want;
    if (!rst) begin
      if (hsv.valid && hsv.ready) begin
        expected_colors.push_back(convert_color(hsv.hue_in, hsv.sat_in, hsv.val_in));
      end
      if (rgb.valid && rgb.ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected RGB transaction r=%0d g=%0d b=%0d", $time,
                   rgb.red_out, rgb.green_out, rgb.blue_out);
          errors = errors + 1;
        end else begin
          want = expected_colors.pop_front();
          if (rgb.red_out !== want.red) begin
            $display("%0t: red wrong for h=%0d s=%0d v=%0d: expected %0d, got %0d", $time,
                     want.hue, want.sat, want.val, want.red, rgb.red_out);
            errors = errors + 1;
          end
          if (rgb.green_out !== want.green) begin
            $display("%0t: green wrong for h=%0d s=%0d v=%0d: expected %0d, got %0d", $time,
                     want.hue, want.sat, want.val, want.green, rgb.green_out);
            errors = errors + 1;
          end
          if (rgb.blue_out !== want.blue) begin
            $display("%0t: blue wrong for h=%0d s=%0d v=%0d: expected %0d, got %0d", $time,
                     want.hue, want.sat, want.val, want.blue, rgb.blue_out);
            errors = errors + 1;
          end
        end
      end
    end
    outstanding = expected_colors.size();
  end

endmodule

// ===== tb/sv/tb_hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives corner colours and then bursts of random colours into the converter
// while the RGB side stalls on shifting patterns; the checker judges results.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsv2rgb_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_CYCLES  = 64;
  localparam int HOLD_BURST   = 40;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HUE_MAX_RAW  = (1 << HUE_W) - 1;
  localparam int LEVEL_MAX_RAW = (1 << LEVEL_W) - 1;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_count;
  bit          hold_request;

  hsv2rgb_hsv_if hsv_ch ();
  hsv2rgb_rgb_if rgb_ch ();

  hsv_to_rgb_converter_top i_dut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv_ch),
    .rgb (rgb_ch)
  );

  hsv_to_rgb_converter_checker i_color_check (
    .clk         (clk),
    .rst         (rst),
    .hsv         (hsv_ch),
    .rgb         (rgb_ch),
    .errors      (fail_count),
    .outstanding (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("hsv_to_rgb_converter_top: mismatch");
    $finish;
  end

  // Offers one colour from a falling edge and holds it until a rising edge takes it.
  task automatic send_color(input hue_t hue, input level_t sat, input level_t val);
    hsv_ch.valid  <= 1'b1;
    hsv_ch.hue_in <= hue;
    hsv_ch.sat_in <= sat;
    hsv_ch.val_in <= val;
    do @(posedge clk); while (!hsv_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      hsv_ch.valid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  task automatic pause_until_drained();
    hsv_ch.valid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
  endtask

  function automatic level_t random_level();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return '0;
      1: return LEVEL_ONE;
      2: return level_t'($urandom_range(0, LEVEL_MAX_RAW));
      3: return LEVEL_ONE - level_t'($urandom_range(0, 255));
      default: return level_t'($urandom_range(0, int'(LEVEL_ONE)));
    endcase
  endfunction

  function automatic hue_t random_hue();
    int unsigned pick;
    int          edge_hue;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return FULL_TURN;
      1: return hue_t'($urandom_range(0, HUE_MAX_RAW));
      2: begin
        // Land on or next to a sector boundary.
        edge_hue = int'($urandom_range(0, 6)) * int'(SECTOR_ONE)
                   + int'($urandom_range(0, 2)) - 1;
        if (edge_hue < 0) edge_hue = 0;
        return hue_t'(edge_hue);
      end
      default: return hue_t'($urandom_range(0, int'(FULL_TURN)));
    endcase
  endfunction

  initial begin : rgb_receiver
    rx_mode_t    mode;
    int unsigned span;
    int unsigned phase;
    rgb_ch.ready = 1'b0;
    phase        = 0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 120);
      for (int unsigned i = 0; i < span; i++) begin
        @(negedge clk);
        phase++;
        if (hold_request) begin
          // Long hold-off so that the pipeline fills and the input backs up.
          hold_request = 1'b0;
          rgb_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
        end else begin
          case (mode)
            RX_ALWAYS:   rgb_ch.ready <= 1'b1;
            RX_COIN:     rgb_ch.ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rgb_ch.ready <= (phase % 3) != 0;
            default:     rgb_ch.ready <= ($urandom_range(0, 5) == 0);
          endcase
        end
      end
    end
  end

  initial begin : hsv_sender
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned hold_at;
    int unsigned drain_at;
    bit          hold_done;
    bit          drain_done;
    rst           = 1'b1;
    hold_request  = 1'b0;
    hsv_ch.valid  = 1'b0;
    hsv_ch.hue_in = '0;
    hsv_ch.sat_in = '0;
    hsv_ch.val_in = '0;
    sent          = 0;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    hold_at       = $urandom_range(100, 400);
    drain_at      = $urandom_range(600, 900);
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Pure red and green, a half-saturated blue, sector edges, grey and black, full turn and out-of-range fields.
    send_color('0, LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(SECTOR_ONE - 1), LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(SECTOR_ONE), LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(SECTOR_ONE) >> 1, LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(2 * SECTOR_ONE), LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(3 * SECTOR_ONE + 1), LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(4 * SECTOR_ONE), LEVEL_ONE >> 1, LEVEL_ONE);
    send_color(hue_t'(5 * SECTOR_ONE + 2048), LEVEL_ONE, LEVEL_ONE >> 1);
    send_color(hue_t'(FULL_TURN - 1), LEVEL_ONE, LEVEL_ONE);
    send_color(FULL_TURN, LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(FULL_TURN + 1), LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(HUE_MAX_RAW), LEVEL_ONE, LEVEL_ONE);
    send_color(hue_t'(1234), '0, LEVEL_ONE);
    send_color(hue_t'(9000), LEVEL_ONE, '0);
    send_color(hue_t'(15000), level_t'(LEVEL_MAX_RAW), LEVEL_ONE);
    send_color(hue_t'(20000), LEVEL_ONE, level_t'(LEVEL_MAX_RAW));
    send_color(hue_t'(7000), level_t'(LEVEL_ONE - 1), level_t'(LEVEL_ONE - 1));
    send_color(hue_t'(11000), level_t'(1), level_t'(1));
    send_color(hue_t'(HUE_MAX_RAW), level_t'(LEVEL_MAX_RAW), level_t'(LEVEL_MAX_RAW));
    send_color('0, '0, '0);
    pause_until_drained();

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 48);
      if (!hold_done && sent >= hold_at) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
        burst        = HOLD_BURST;
      end
      repeat (burst) send_color(random_hue(), random_level(), random_level());
      sent += burst;
      if (!drain_done && sent >= drain_at) begin
        drain_done = 1'b1;
        pause_until_drained();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        idle_sender(gap);
      end
    end

    hsv_ch.valid <= 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("hsv_to_rgb_converter_top: match");
    end else begin
      $display("hsv_to_rgb_converter_top: mismatch");
    end
    $finish;
  end

endmodule
